@@ hw/rtl/kna_pkg.sv @@
// Shared types, constants and codes for the k-means nearest centroid block.
`default_nettype none
package kna_pkg;

   localparam int MAX_CLUSTERS_DEF  = 32;
   localparam int VECTOR_LENGTH_DEF = 64;

   localparam int ACC_W   = 40;
   localparam int SQ_IN_W = 56;
   localparam int SQ_RT_W = SQ_IN_W / 2;
   localparam int DIVD_W  = 56;
   localparam int DIVS_W  = 40;

   localparam logic       FUNC_LOAD  = 1'b0;
   localparam logic       FUNC_POINT = 1'b1;
   localparam logic       CSR_COSINE = 1'b0;
   localparam logic       CSR_ACTIVE = 1'b1;
   localparam logic [31:0] DIST_COS_ZERO = 32'd131072;
   localparam logic [31:0] COS_ONE       = 32'd65536;
   localparam logic [5:0]  ACTIVE_RESET  = 6'd20;

   typedef struct packed {
      logic               func;
      logic [4:0]         cluster_index;
      logic [5:0]         element_index;
      logic signed [15:0] value;
      logic               last_element;
      logic [4:0]         previous_cluster;
   } req_type;

   typedef struct packed {
      logic [4:0]  nearest_cluster;
      logic [31:0] distance;
      logic        changed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_FRD,
      ST_FLAT,
      ST_SQ1,
      ST_SQ2,
      ST_MUL,
      ST_DIV,
      ST_CMP,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

@@ hw/rtl/kna_sqrt.sv @@
// Iterative integer square root, one root bit per cycle.
`default_nettype none
module kna_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [kna_pkg::SQ_IN_W-1:0] x,
   output logic                            done,
   output logic [kna_pkg::SQ_RT_W-1:0]     root
);
   import kna_pkg::*;

   localparam int CNT_W = $clog2(SQ_RT_W);

   logic [SQ_IN_W-1:0] x_ff, x_in;
   logic [SQ_RT_W+1:0] rem_ff, rem_in;
   logic [SQ_RT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SQ_RT_W+3:0] rem_sh;
   logic [SQ_RT_W+3:0] trial;

   always_comb begin
      rem_sh  = {rem_ff, x_ff[SQ_IN_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         x_in    = x;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQ_RT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[SQ_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (SQ_RT_W+2)'(rem_sh - trial);
            root_in = {root_ff[SQ_RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[SQ_RT_W+1:0];
            root_in = {root_ff[SQ_RT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

@@ hw/rtl/kna_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module kna_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [kna_pkg::DIVD_W-1:0] dividend,
   input  wire logic [kna_pkg::DIVS_W-1:0] divisor,
   output logic                           done,
   output logic [kna_pkg::DIVD_W-1:0]     quotient
);
   import kna_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W);

   logic [DIVD_W-1:0] q_ff, q_in;
   logic [DIVS_W-1:0] d_ff, d_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   sh;

   always_comb begin
      // quotient register doubles as the dividend shifter
      sh      = {rem_ff, q_ff[DIVD_W-1]};
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         q_in    = dividend;
         d_in    = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            rem_in = DIVS_W'(sh - {1'b0, d_ff});
            q_in   = {q_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = sh[DIVS_W-1:0];
            q_in   = {q_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

@@ hw/rtl/kmeans_nearest_centroid_assign_top.sv @@
// Top level of the k-means nearest centroid assignment block.
// A load transaction writes one centroid element into the centroid RAM. A
// point element in range walks all MAX_CLUSTERS centroids through the RAM
// read pipeline, one centroid a cycle, and holds off the input until the
// pipeline has drained; an out-of-range point element adds nothing, though
// scoring still follows if it is the last element. On the last element the
// active centroids are scored one after another through a shared bit-serial
// square root and divider: one root per centroid in Euclidean mode, and two
// roots, one multiply and a 56-bit division in cosine mode. The result sits
// in an output register, so the next element is taken while it waits.
// Centroid entries that were never loaded read as garbage.
`default_nettype none
module kmeans_nearest_centroid_assign_top #(
   parameter int MAX_CLUSTERS  = kna_pkg::MAX_CLUSTERS_DEF,
   parameter int VECTOR_LENGTH = kna_pkg::VECTOR_LENGTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kna_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kna_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [5:0]       csr_wdata
);
   import kna_pkg::*;

   localparam int CW    = $clog2(MAX_CLUSTERS);
   localparam int DEPTH = MAX_CLUSTERS * VECTOR_LENGTH;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [ACC_W-1:0] sat_u(input logic [ACC_W:0] s);
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_s(input logic signed [ACC_W:0] s);
      logic signed [ACC_W-1:0] r;
      if (s[ACC_W] != s[ACC_W-1])
         r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         r = s[ACC_W-1:0];
      return r;
   endfunction

   // storage
   logic [15:0]             cmem [DEPTH];
   logic [ACC_W-1:0]        sd_mem [MAX_CLUSTERS];
   logic signed [ACC_W-1:0] dp_mem [MAX_CLUSTERS];
   logic [ACC_W-1:0]        cm_mem [MAX_CLUSTERS];

   state_type state_ff, state_in;
   logic      cosine_ff;
   logic [5:0] active_ff;
   req_type   item_ff;
   logic      fresh_ff;
   logic [ACC_W-1:0] pm_ff;
   logic [ACC_W-1:0] pm_eff;

   logic      accept;
   logic      load_ok;
   logic      elem_ok;
   logic [AW-1:0] load_addr;
   logic [AW-1:0] pass_addr;

   // pass pipeline
   logic [CW-1:0] pc_ff;
   logic          issue_done_ff;
   logic          issue;
   logic          pass_done;
   logic          s1_v_ff;
   logic [CW-1:0] s1_idx_ff;
   logic [15:0]   crd_ff;
   logic [ACC_W-1:0]        sd_rd_ff;
   logic signed [ACC_W-1:0] dp_rd_ff;
   logic [ACC_W-1:0]        cm_rd_ff;
   logic          s2_v_ff;
   logic [CW-1:0] s2_idx_ff;
   logic [32:0]   dsq_ff;
   logic signed [31:0] mv_ff;
   logic [30:0]   mm_ff;
   logic [ACC_W-1:0]        sd_b_ff;
   logic signed [ACC_W-1:0] dp_b_ff;
   logic [ACC_W-1:0]        cm_b_ff;
   logic signed [16:0] diff;
   logic signed [33:0] dsq_full;
   logic [CW-1:0] acc_raddr;

   // scoring
   logic [CW-1:0] fc_ff;
   logic [CW-1:0] last_c_ff;
   logic [CW-1:0] best_ff;
   logic [31:0]   best_d_ff;
   logic [31:0]   d_ff;
   logic signed [ACC_W-1:0] dot_ff;
   logic [ACC_W-1:0] sd_f, cm_f;
   logic signed [ACC_W-1:0] dp_f;
   logic [19:0]   r1_ff;
   logic [DIVS_W-1:0] den_ff;
   logic [ACC_W-1:0] dot_mag;
   logic [56:0]   cos_sum;
   logic [31:0]   cos_d;
   int            cnt_int;

   logic          sq_start;
   logic [SQ_IN_W-1:0] sq_x;
   logic          sq_done;
   logic [SQ_RT_W-1:0] sq_root;
   logic          div_start;
   logic          div_done;
   logic [DIVD_W-1:0] div_q;

   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          rsp_free;
   logic [31:0]   best_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_ok   = (32'(req_data.cluster_index) < MAX_CLUSTERS) &&
                      (32'(req_data.element_index) < VECTOR_LENGTH);
   assign elem_ok   = 32'(req_data.element_index) < VECTOR_LENGTH;
   assign load_addr = AW'(32'(req_data.cluster_index) * VECTOR_LENGTH +
                          32'(req_data.element_index));
   assign pass_addr = AW'(32'(pc_ff) * VECTOR_LENGTH + 32'(item_ff.element_index));
   assign issue     = (state_ff == ST_PASS) && !issue_done_ff;
   assign pass_done = (state_ff == ST_PASS) && issue_done_ff && !s1_v_ff && !s2_v_ff;
   assign acc_raddr = (state_ff == ST_PASS) ? pc_ff : fc_ff;
   assign pm_eff    = fresh_ff ? '0 : pm_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign diff     = 17'(signed'(crd_ff)) - 17'(item_ff.value);
   assign dsq_full = diff * diff;

   // accumulators read as zero until the point's first element lands
   assign sd_f = fresh_ff ? '0 : sd_rd_ff;
   assign dp_f = fresh_ff ? '0 : dp_rd_ff;
   assign cm_f = fresh_ff ? '0 : cm_rd_ff;

   assign dot_mag = dot_ff[ACC_W-1] ? ACC_W'(-dot_ff) : dot_ff;
   assign cos_sum = dot_ff[ACC_W-1] ? 57'(COS_ONE) + 57'(div_q) : 57'(COS_ONE) - 57'(div_q);

   always_comb begin
      if (dot_ff[ACC_W-1])
         cos_d = (cos_sum > 57'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cos_sum[31:0];
      else
         cos_d = (div_q >= DIVD_W'(COS_ONE)) ? 32'd0 : cos_sum[31:0];
   end

   always_comb begin
      if (active_ff == 6'd0)
         cnt_int = 1;
      else if (32'(active_ff) > MAX_CLUSTERS)
         cnt_int = MAX_CLUSTERS;
      else
         cnt_int = 32'(active_ff);
   end

   always_comb begin
      state_in  = state_ff;
      sq_start  = 1'b0;
      sq_x      = {sd_f, 16'd0};
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.func == FUNC_POINT) begin
               if (elem_ok)
                  state_in = ST_PASS;
               else if (req_data.last_element)
                  state_in = ST_FRD;
            end
         end
         ST_PASS: begin
            if (pass_done)
               state_in = item_ff.last_element ? ST_FRD : ST_IDLE;
         end
         ST_FRD: state_in = ST_FLAT;
         ST_FLAT: begin
            if (!cosine_ff) begin
               sq_start = 1'b1;
               state_in = ST_SQ1;
            end else if (cm_f == '0 || pm_eff == '0) begin
               state_in = ST_CMP;
            end else begin
               sq_start = 1'b1;
               sq_x     = SQ_IN_W'(cm_f);
               state_in = ST_SQ1;
            end
         end
         ST_SQ1: begin
            if (sq_done) begin
               if (cosine_ff) begin
                  sq_start = 1'b1;
                  sq_x     = SQ_IN_W'(pm_eff);
                  state_in = ST_SQ2;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_SQ2: if (sq_done) state_in = ST_MUL;
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: if (div_done) state_in = ST_CMP;
         ST_CMP: state_in = (fc_ff == last_c_ff) ? ST_OUT : ST_FRD;
         ST_OUT: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cosine_ff <= 1'b0;
         active_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COSINE: cosine_ff <= csr_wdata[0];
            CSR_ACTIVE: active_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // centroid RAM
   always_ff @(posedge clock) begin
      if (accept && req_data.func == FUNC_LOAD && load_ok)
         cmem[load_addr] <= req_data.value;
      crd_ff <= cmem[pass_addr];
   end

   // accumulator RAMs, written back from stage s2 after the read
   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         sd_mem[s2_idx_ff] <= sat_u({1'b0, sd_b_ff} + (ACC_W+1)'(dsq_ff));
         dp_mem[s2_idx_ff] <= sat_s((ACC_W+1)'(dp_b_ff) + (ACC_W+1)'(mv_ff));
         cm_mem[s2_idx_ff] <= sat_u({1'b0, cm_b_ff} + (ACC_W+1)'(mm_ff));
      end
      sd_rd_ff <= sd_mem[acc_raddr];
      dp_rd_ff <= dp_mem[acc_raddr];
      cm_rd_ff <= cm_mem[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept)
         item_ff <= req_data;
      if (accept)
         pc_ff <= '0;
      else if (issue)
         pc_ff <= pc_ff + 1'b1;
      s1_idx_ff <= pc_ff;
      s2_idx_ff <= s1_idx_ff;
      dsq_ff    <= dsq_full[32:0];
      mv_ff     <= 32'(signed'(crd_ff)) * 32'(item_ff.value);
      mm_ff     <= 31'(32'(signed'(crd_ff)) * 32'(signed'(crd_ff)));
      sd_b_ff   <= sd_f;
      dp_b_ff   <= dp_f;
      cm_b_ff   <= cm_f;
      if (pass_done)
         pm_ff <= sat_u({1'b0, pm_eff} +
                        (ACC_W+1)'(32'(item_ff.value) * 32'(item_ff.value)));
      if (reset) begin
         issue_done_ff <= 1'b1;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         fresh_ff      <= 1'b1;
      end else begin
         if (accept)
            issue_done_ff <= 1'b0;
         else if (issue && 32'(pc_ff) == MAX_CLUSTERS - 1)
            issue_done_ff <= 1'b1;
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         if (pass_done)
            fresh_ff <= 1'b0;
         else if (state_ff == ST_OUT && rsp_free)
            fresh_ff <= 1'b1;
      end
   end

   // scoring datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_PASS || state_ff == ST_IDLE) begin
         fc_ff     <= '0;
         last_c_ff <= CW'(cnt_int - 1);
      end else if (state_ff == ST_CMP) begin
         fc_ff <= fc_ff + 1'b1;
      end
      if (state_ff == ST_FLAT) begin
         dot_ff <= dp_f;
         d_ff   <= DIST_COS_ZERO;
      end
      if (state_ff == ST_SQ1 && sq_done) begin
         r1_ff <= sq_root[19:0];
         d_ff  <= 32'(sq_root);
      end
      if (state_ff == ST_SQ2 && sq_done)
         den_ff <= DIVS_W'(r1_ff) * DIVS_W'(sq_root[19:0]);
      if (state_ff == ST_DIV && div_done)
         d_ff <= cos_d;
      if (state_ff == ST_CMP && (fc_ff == '0 || d_ff < best_d_ff)) begin
         best_ff   <= fc_ff;
         best_d_ff <= d_ff;
      end
   end

   kna_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .x     (sq_x),
      .done  (sq_done),
      .root  (sq_root)
   );

   kna_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({dot_mag, 16'd0}),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // result register
   assign best_ext = 32'(best_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_data_ff.nearest_cluster <= best_ext[4:0];
         rsp_data_ff.distance        <= best_d_ff;
         rsp_data_ff.changed         <= (best_ext[4:0] != item_ff.previous_cluster);
      end
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (state_ff == ST_OUT && rsp_free)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !s1_v_ff && !s2_v_ff)
      else $error("pass pipeline busy while idle");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && issue |-> s2_idx_ff != pc_ff)
      else $error("accumulator write back collides with read");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

endmodule
`default_nettype wire
